// File: rtl/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timestamp queue
// Command and status codes, word widths and the per-cycle cell control.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int STAMP_W   = 32;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [STAMP_W-1:0] EMPTY_STAMP = {STAMP_W{1'b1}};

   // Broadcast to every cell in the chain for one accepted word.
   typedef struct packed {
      logic                      ins;
      logic                      pop;
      logic                      clr;
      logic signed [STAMP_W-1:0] stamp;
   } stq_ctl_type;

endpackage
`default_nettype wire

// File: rtl/stq_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ifs: valid/ready channels of the sorted timestamp queue
// Request channel carries a command word, response channel a result word.
// ----------------------------------------------------------------------------
interface stq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [stq_pkg::CMD_W-1:0]            command;
   logic signed [stq_pkg::STAMP_W-1:0]   stamp_in;

   modport source (output valid, output command, output stamp_in, input ready);
   modport sink   (input valid, input command, input stamp_in, output ready);
endinterface

interface stq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [stq_pkg::STATUS_W-1:0]         status;
   logic signed [stq_pkg::STAMP_W-1:0]   stamp_out;
   logic [stq_pkg::FILL_W-1:0]           fill_count;

   modport source (output valid, output status, output stamp_out, output fill_count,
                   input ready);
   modport sink   (input valid, input status, input stamp_out, input fill_count,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/stq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted chain
// Holds one stamp and its valid bit; inserts, shifts up or shifts down.
// ----------------------------------------------------------------------------
module stq_cell (
   input  wire                                clock,
   input  wire                                reset,
   input  wire stq_pkg::stq_ctl_type          ctl,
   input  wire                                left_flag,
   input  wire logic [stq_pkg::STAMP_W-1:0]   left_slot,
   input  wire                                left_valid,
   input  wire logic [stq_pkg::STAMP_W-1:0]   right_slot,
   input  wire                                right_valid,
   output logic                               flag,
   output logic [stq_pkg::STAMP_W-1:0]        slot,
   output logic                               valid
);

   logic [stq_pkg::STAMP_W-1:0] slot_ff, slot_in;
   logic                        valid_ff, valid_in;

   // Flag marks a cell the new stamp goes in front of (free, or strictly larger).
   assign flag  = !valid_ff || (ctl.stamp < $signed(slot_ff));
   assign slot  = slot_ff;
   assign valid = valid_ff;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      priority if (ctl.clr) begin
         slot_in  = stq_pkg::EMPTY_STAMP;
         valid_in = 1'b0;
      end else if (ctl.ins) begin
         if (left_flag) begin
            slot_in  = left_slot;
            valid_in = left_valid;
         end else if (flag) begin
            slot_in  = ctl.stamp;
            valid_in = 1'b1;
         end
      end else if (ctl.pop) begin
         slot_in  = right_slot;
         valid_in = right_valid;
      end else begin
         // idle cycle: hold the slot
         slot_in  = slot_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= stq_pkg::EMPTY_STAMP;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/sorted_timestamp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// A response word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle while the response side takes its words; every
//   cell compares and shifts in the same cycle, and the response register frees itself when the word is taken.
// Reset (synchronous): every slot returns to -1, the queue is empty, the
//   response register holds nothing. No clearing pass is needed.
// ----------------------------------------------------------------------------
// sorted_timestamp_queue: bounded min-priority queue of signed timestamps
// A row of DEPTH cells keeps the stamps in ascending order; insert drops the
// new stamp after every equal or smaller entry, pop takes the head.
// ----------------------------------------------------------------------------
module sorted_timestamp_queue #(
   parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   stq_req_if.sink    req_chan,
   stq_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // Cell outputs, each read at its own fixed neighbor position.
   logic                        cell_flag  [DEPTH];
   logic [stq_pkg::STAMP_W-1:0] cell_slot  [DEPTH];
   logic                        cell_valid [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;

   logic                           rsp_valid_ff;
   logic [stq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [stq_pkg::STAMP_W-1:0]    rsp_stamp_ff, rsp_stamp_in;
   logic [stq_pkg::FILL_W-1:0]     rsp_fill_ff;
   logic [CNT_W+stq_pkg::FILL_W-1:0] fill_ext;

   logic               accept;
   logic               full;
   logic               empty;
   stq_pkg::stq_ctl_type ctl;

   // Take a new word whenever the response register is free or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // The chain fills from the head, so the tail and head valid bits tell it all.
   assign full  = cell_valid[DEPTH-1];
   assign empty = !cell_valid[0];

   always_comb begin
      ctl           = '0;
      ctl.stamp     = req_chan.stamp_in;
      count_in      = count_ff;
      rsp_status_in = stq_pkg::ST_DONE;
      rsp_stamp_in  = '0;
      if (accept) begin
         unique case (req_chan.command)
            stq_pkg::CMD_INSERT: begin
               if (full) begin
                  rsp_status_in = stq_pkg::ST_FULL;
               end else begin
                  ctl.ins  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            stq_pkg::CMD_POP: begin
               if (empty) begin
                  rsp_status_in = stq_pkg::ST_EMPTY;
               end else begin
                  ctl.pop      = 1'b1;
                  rsp_stamp_in = cell_slot[0];
                  count_in     = count_ff - 1'b1;
               end
            end
            stq_pkg::CMD_CLEAR: begin
               ctl.clr  = 1'b1;
               count_in = '0;
            end
            default: begin
               // unused command: leave the queue alone, report the count
            end
         endcase
      end
   end

   // Build the chain: each cell sees its lower neighbor for insert shifts and
   // its upper neighbor for pop shifts; the ends see an empty slot.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                        l_flag, l_valid, r_valid;
      logic [stq_pkg::STAMP_W-1:0] l_slot, r_slot;

      if (i == 0) begin : g_head
         assign l_flag  = 1'b0;
         assign l_slot  = stq_pkg::EMPTY_STAMP;
         assign l_valid = 1'b0;
      end else begin : g_body
         assign l_flag  = cell_flag[i-1];
         assign l_slot  = cell_slot[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_slot  = stq_pkg::EMPTY_STAMP;
         assign r_valid = 1'b0;
      end else begin : g_mid
         assign r_slot  = cell_slot[i+1];
         assign r_valid = cell_valid[i+1];
      end

      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_flag   (l_flag),
         .left_slot   (l_slot),
         .left_valid  (l_valid),
         .right_slot  (r_slot),
         .right_valid (r_valid),
         .flag        (cell_flag[i]),
         .slot        (cell_slot[i]),
         .valid       (cell_valid[i])
      );
   end

   // Report the count masked to the field width.
   assign fill_ext = {{stq_pkg::FILL_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the payload until the next accepted word replaces it.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_stamp_ff  <= rsp_stamp_in;
         rsp_fill_ff   <= fill_ext[stq_pkg::FILL_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.stamp_out  = rsp_stamp_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted timestamp queue
// Drives insert, pop, clear and unused command words with random gaps and
// back-pressure. A mirror of the sorted slot row predicts every result word,
// and each taken result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import stq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;
   localparam int TOTAL_WORDS = 1550;
   localparam int LIMIT_NS    = 2_000_000;

   // The package names three commands; the fourth code must do nothing.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [STAMP_W-1:0]  stamp;
      logic [FILL_W-1:0]          fill;
   } queue_result_type;

   // Mirror of the slot row plus the list of result words still owed.
   class sorted_queue_mirror;
      logic signed [STAMP_W-1:0] slot_row [QUEUE_DEPTH];
      int                        occupied;
      queue_result_type          owed_results [$];
      int                        mismatch_count;

      function new();
         empty_row();
         mismatch_count = 0;
      endfunction

      function void empty_row();
         foreach (slot_row[i]) slot_row[i] = EMPTY_STAMP;
         occupied = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Apply one accepted command word to the mirror and owe its result.
      function void note_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [STAMP_W-1:0] stamp);
         queue_result_type owed;
         int               pos;
         int               i;
         owed.status = ST_DONE;
         owed.stamp  = '0;
         case (cmd)
            CMD_INSERT: begin
               if (occupied >= QUEUE_DEPTH) begin
                  owed.status = ST_FULL;
               end else begin
                  // land after every entry that is less than or equal
                  pos = occupied;
                  for (i = 0; i < occupied; i++) begin
                     if (stamp < slot_row[i]) begin
                        pos = i;
                        break;
                     end
                  end
                  for (i = occupied; i > pos; i--) slot_row[i] = slot_row[i-1];
                  slot_row[pos] = stamp;
                  occupied++;
               end
            end
            CMD_POP: begin
               if (occupied == 0) begin
                  owed.status = ST_EMPTY;
               end else begin
                  owed.stamp = slot_row[0];
                  for (i = 1; i < occupied; i++) slot_row[i-1] = slot_row[i];
                  slot_row[occupied-1] = EMPTY_STAMP;
                  occupied--;
               end
            end
            CMD_CLEAR: empty_row();
            default: ;
         endcase
         owed.fill = FILL_W'(occupied);
         owed_results.push_back(owed);
      endfunction

      // Compare one taken result word with the oldest owed one.
      function void check_result(input logic [STATUS_W-1:0] status,
                                 input logic signed [STAMP_W-1:0] stamp,
                                 input logic [FILL_W-1:0] fill);
         queue_result_type owed;
         if (owed_results.size() == 0) begin
            $display("%0t: result word with none owed: status %0d stamp %0d fill %0d",
                     $time, status, stamp, fill);
            mismatch_count++;
            return;
         end
         owed = owed_results.pop_front();
         if (status !== owed.status) begin
            $display("%0t: status expected %0d, got %0d", $time, owed.status, status);
            mismatch_count++;
         end
         if (stamp !== owed.stamp) begin
            $display("%0t: stamp_out expected %0d, got %0d", $time, owed.stamp, stamp);
            mismatch_count++;
         end
         if (fill !== owed.fill) begin
            $display("%0t: fill_count expected %0d, got %0d", $time, owed.fill, fill);
            mismatch_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   stq_req_if req_if ();
   stq_rsp_if rsp_if ();

   sorted_queue_mirror mirror = new();

   // Idle odds in percent for each side, and a receiver hold-off request.
   int src_idle_pct    = 33;
   int sink_idle_pct   = 33;
   int hold_off_cycles = 0;
   int words_sent      = 0;

   sorted_timestamp_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // Watch both channels at the edge: note the accepted command word first,
   // so ordering holds even if a result word could follow in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            mirror.note_command(req_if.command, req_if.stamp_in);
         if (rsp_if.valid && rsp_if.ready)
            mirror.check_result(rsp_if.status, rsp_if.stamp_out, rsp_if.fill_count);
      end
   end

   // Receiver: drop ready at random, or hold it low for a counted stretch
   // when the stimulus asks for back-pressure.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Mix extremes, a narrow band that makes equal stamps common, and
   // full-range values.
   function automatic logic signed [STAMP_W-1:0] pick_stamp();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Offer one command word after an optional random gap, and hold it
   // until the block takes it.
   task automatic send_word(input logic [CMD_W-1:0] cmd,
                            input logic signed [STAMP_W-1:0] stamp);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.stamp_in <= stamp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   // Stop offering and wait until every owed result word has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   // A run of commands leaning toward inserts or pops; noise adds clears
   // and the unused code.
   task automatic run_burst(input int count, input int insert_pct, input int noise_pct);
      int               k;
      logic [CMD_W-1:0] cmd;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < noise_pct)
            cmd = $urandom_range(1) ? CMD_CLEAR : CMD_UNUSED;
         else if ($urandom_range(99) < insert_pct)
            cmd = CMD_INSERT;
         else
            cmd = CMD_POP;
         send_word(cmd, pick_stamp());
      end
   endtask

   // Main stimulus.
   initial begin
      int  k;
      int  pick;
      bit  hold_done;
      bit  pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.command  <= CMD_INSERT;
      req_if.stamp_in <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on the empty queue, extremes and equal stamps, then
      // fill to the brim and push once more to see the rejection.
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_INSERT, 32'sh7FFF_FFFF);
      send_word(CMD_INSERT, 32'sh8000_0000);
      send_word(CMD_INSERT, 32'sd0);
      send_word(CMD_INSERT, -32'sd1);
      send_word(CMD_INSERT, 32'sd5);
      send_word(CMD_INSERT, 32'sd5);
      for (k = 0; k < QUEUE_DEPTH - 6; k++) send_word(CMD_INSERT, pick_stamp());
      send_word(CMD_INSERT, 32'sd7);
      // unused code: nothing changes, count reported as is
      send_word(CMD_UNUSED, 32'sh5A5A_A5A5);
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_CLEAR, 32'sd0);
      send_word(CMD_POP, 32'sd0);

      // Random: mostly fill and drain runs so both full and empty are
      // reached often, with mixed runs and a little noise.
      while (words_sent < TOTAL_WORDS) begin
         // back-pressure: the receiver holds off while words keep coming
         if (!hold_done && words_sent >= 400) begin
            hold_off_cycles = 300;
            hold_done       = 1'b1;
         end
         // sender pause until the pipe is empty
         if (!pause_done && words_sent >= 800) begin
            wait_drained();
            pause_done = 1'b1;
         end
         // a stretch with no gaps on either side
         if (words_sent >= 1000 && words_sent < 1300) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end else begin
            src_idle_pct  = 33;
            sink_idle_pct = 33;
         end
         pick = $urandom_range(99);
         if (pick < 40)
            run_burst($urandom_range(4, 20), 85, 0);
         else if (pick < 75)
            run_burst($urandom_range(4, 20), 15, 0);
         else if (pick < 92)
            run_burst($urandom_range(4, 20), 50, 3);
         else
            run_burst($urandom_range(1, 4), 40, 60);
      end

      // Drain, then keep watching for any stray result word before the verdict.
      wait_drained();
      repeat (8) @(posedge clock);
      if (mirror.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Hang guard.
   initial begin
      #(LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
